// ===== hdl/bmsc_pkg.sv =====
// Shared constants and controller/datapath interface types for the bipartite cover block.
package bmsc_pkg;

    localparam int VERT_IN_W = 7;
    localparam int TOTAL_W   = 6;

    localparam logic [TOTAL_W-1:0]   TOTAL_MAX          = 6'd63;
    localparam logic [VERT_IN_W-1:0] NUM_VERTICES_RESET = 7'd64;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_FINISH   = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load_edge;
        logic walk_init;
        logic root_next;
        logic root_start;
        logic pop_req;
        logic pop_load;
        logic scan_issue;
        logic comp_done;
        logic capture;
    } bmsc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic root_done;
        logic root_visited;
        logic stack_empty;
        logic scan_last;
    } bmsc_status_t;

endpackage

// ===== hdl/bmsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bmsc_ctrl.sv =====
// Sequencer for edge loading, depth-first two-coloring walk, result and clearing pass.
module bmsc_ctrl
    import bmsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         cmd,
    input  bmsc_status_t status,
    output bmsc_cmd_t    dp_cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_COMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    assign accept = start & ~busy_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_FINISH)
                    begin
                        dp_cmd.walk_init = 1'b1;
                        state_next       = ST_ROOT;
                    end
                    else
                    begin
                        dp_cmd.load_edge = 1'b1;
                    end
                end
            end
            ST_ROOT:
            begin
                priority if (status.root_done)
                begin
                    dp_cmd.capture = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_CLEAR;
                end
                else if (status.root_visited)
                begin
                    dp_cmd.root_next = 1'b1;
                end
                else
                begin
                    dp_cmd.root_start = 1'b1;
                    state_next        = ST_POP;
                end
            end
            ST_POP:
            begin
                if (status.stack_empty)
                begin
                    state_next = ST_COMP;
                end
                else
                begin
                    dp_cmd.pop_req = 1'b1;
                    state_next     = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                dp_cmd.pop_load = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                dp_cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_POP;
            end
            ST_COMP:
            begin
                dp_cmd.comp_done = 1'b1;
                state_next       = ST_ROOT;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hdl/bmsc_datapath.sv =====
// Adjacency memories, walk stack, visit/color vectors, counters and result registers.
module bmsc_datapath
    import bmsc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmsc_cmd_t            dp_cmd,
    output bmsc_status_t         status,
    input  logic [VERT_IN_W-1:0] end_a,
    input  logic [VERT_IN_W-1:0] end_b,
    input  logic                 cfg_wr_en,
    input  logic [VERT_IN_W-1:0] cfg_wr_data,
    output logic [TOTAL_W-1:0]   min_guards,
    output logic                 impossible
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int NW    = (CNT_W > VERT_IN_W) ? CNT_W : VERT_IN_W;
    localparam int SW    = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
    localparam int AW    = 2 * VW;

    logic [VERT_IN_W-1:0]    num_vertices_reg;
    logic [CNT_W-1:0]        n_eff;
    logic [NW-1:0]           num_ext;
    logic [NW-1:0]           a_ext;
    logic [NW-1:0]           b_ext;
    logic [NW-1:0]           a_m1;
    logic [NW-1:0]           b_m1;
    logic [VW-1:0]           a_idx;
    logic [VW-1:0]           b_idx;
    logic                    edge_ok;

    logic [AW-1:0]           clr_addr_reg;
    logic [CNT_W-1:0]        s_reg;
    logic [VW-1:0]           s_idx;
    logic [VW-1:0]           u_reg;
    logic [VW-1:0]           w_reg;
    logic [VW-1:0]           proc_w_reg;
    logic                    proc_valid_reg;
    logic [CNT_W-1:0]        depth_reg;
    logic [CNT_W-1:0]        depth_m1;
    logic [CNT_W-1:0]        c1_reg;
    logic [CNT_W-1:0]        c0_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic                    conflict_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] color_reg;
    logic [TOTAL_W-1:0]      min_guards_reg;
    logic                    impossible_reg;

    logic                    ram_we;
    logic [AW-1:0]           fwd_waddr;
    logic [AW-1:0]           rev_waddr;
    logic                    ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic                    fwd_rdata;
    logic                    rev_rdata;

    logic                    st_we;
    logic [VW-1:0]           st_wdata;
    logic [VW-1:0]           st_rdata;

    logic                    cu;
    logic                    w_seen;
    logic                    proc_hit;
    logic                    proc_new;
    logic                    proc_conf;
    logic                    push_new;
    logic [CNT_W-1:0]        min_c;
    logic [SW-1:0]           sum;
    logic [TOTAL_W-1:0]      total_next;

    // effective vertex count: register value capped at the array size
    assign num_ext = NW'(num_vertices_reg);
    assign n_eff   = (num_ext > NW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(num_ext);

    assign a_ext   = NW'(end_a);
    assign b_ext   = NW'(end_b);
    assign a_m1    = a_ext - NW'(1);
    assign b_m1    = b_ext - NW'(1);
    assign a_idx   = a_m1[VW-1:0];
    assign b_idx   = b_m1[VW-1:0];
    assign edge_ok = (end_a != '0) && (end_b != '0)
                     && (a_ext <= NW'(n_eff)) && (b_ext <= NW'(n_eff));

    // adjacency held as two bit memories, one per edge orientation
    assign ram_we    = dp_cmd.clr_step | (dp_cmd.load_edge & edge_ok);
    assign fwd_waddr = dp_cmd.clr_step ? clr_addr_reg : {a_idx, b_idx};
    assign rev_waddr = dp_cmd.clr_step ? clr_addr_reg : {b_idx, a_idx};
    assign ram_wdata = ~dp_cmd.clr_step;
    assign ram_raddr = {u_reg, w_reg};

    bmsc_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_adj_fwd (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fwd_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (fwd_rdata)
    );

    bmsc_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_adj_rev (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rev_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rev_rdata)
    );

    // neighbor check, in the cycle after the read issue
    assign s_idx     = s_reg[VW-1:0];
    assign cu        = color_reg[u_reg];
    assign w_seen    = visited_reg[proc_w_reg];
    assign proc_hit  = proc_valid_reg & (fwd_rdata | rev_rdata);
    assign proc_new  = proc_hit & ~w_seen;
    assign proc_conf = proc_hit & w_seen & (color_reg[proc_w_reg] == cu);
    assign push_new  = proc_new & (depth_reg < CNT_W'(MAX_VERTICES));

    assign depth_m1 = depth_reg - CNT_W'(1);
    assign st_we    = dp_cmd.root_start | push_new;
    assign st_wdata = dp_cmd.root_start ? s_idx : proc_w_reg;

    bmsc_ram #(
        .WIDTH (VW),
        .DEPTH (1 << VW)
    ) u_walk_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (depth_reg[VW-1:0]),
        .wdata (st_wdata),
        .raddr (depth_m1[VW-1:0]),
        .rdata (st_rdata)
    );

    assign min_c      = (c1_reg < c0_reg) ? c1_reg : c0_reg;
    assign sum        = SW'(total_reg) + SW'(min_c);
    assign total_next = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= NUM_VERTICES_RESET;
            clr_addr_reg     <= '0;
            s_reg            <= '0;
            depth_reg        <= '0;
            proc_valid_reg   <= 1'b0;
            total_reg        <= '0;
            conflict_reg     <= 1'b0;
            c1_reg           <= CNT_W'(1);
            c0_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_vertices_reg <= cfg_wr_data;
            end
            if (dp_cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            proc_valid_reg <= dp_cmd.scan_issue;

            if (dp_cmd.walk_init)
            begin
                s_reg        <= '0;
                total_reg    <= '0;
                conflict_reg <= 1'b0;
            end
            else if (dp_cmd.root_next)
            begin
                s_reg <= s_reg + CNT_W'(1);
            end

            priority if (dp_cmd.walk_init)
            begin
                depth_reg <= '0;
            end
            else if (dp_cmd.root_start)
            begin
                depth_reg <= CNT_W'(1);
            end
            else if (dp_cmd.pop_req)
            begin
                depth_reg <= depth_m1;
            end
            else if (push_new)
            begin
                depth_reg <= depth_reg + CNT_W'(1);
            end

            priority if (dp_cmd.root_start)
            begin
                c1_reg <= CNT_W'(1);
                c0_reg <= '0;
            end
            else if (proc_new)
            begin
                if (!cu)
                begin
                    c1_reg <= c1_reg + CNT_W'(1);
                end
                else
                begin
                    c0_reg <= c0_reg + CNT_W'(1);
                end
            end

            if (dp_cmd.comp_done)
            begin
                total_reg <= total_next;
            end
            if (proc_conf)
            begin
                conflict_reg <= 1'b1;
            end
        end
    end

    // vectors are cleared at the start of every walk before use
    always_ff @(posedge clk)
    begin
        if (dp_cmd.walk_init)
        begin
            visited_reg <= '0;
            color_reg   <= '0;
        end
        else if (dp_cmd.root_start)
        begin
            visited_reg[s_idx] <= 1'b1;
            color_reg[s_idx]   <= 1'b1;
        end
        else if (proc_new)
        begin
            visited_reg[proc_w_reg] <= 1'b1;
            color_reg[proc_w_reg]   <= ~cu;
        end

        if (dp_cmd.pop_load)
        begin
            u_reg <= st_rdata;
            w_reg <= '0;
        end
        else if (dp_cmd.scan_issue)
        begin
            w_reg <= w_reg + VW'(1);
        end
        proc_w_reg <= w_reg;

        if (dp_cmd.capture)
        begin
            min_guards_reg <= conflict_reg ? '0 : total_reg;
            impossible_reg <= conflict_reg;
        end
    end

    assign status.clr_last     = &clr_addr_reg;
    assign status.root_done    = (s_reg >= n_eff);
    assign status.root_visited = visited_reg[s_idx];
    assign status.stack_empty  = (depth_reg == '0);
    assign status.scan_last    = (CNT_W'(w_reg) == (n_eff - CNT_W'(1)));

    assign min_guards = min_guards_reg;
    assign impossible = impossible_reg;

endmodule

// ===== hdl/bipartite_min_side_cover.sv =====
// Top level: bipartite two-coloring with per-component smaller-class sum.
// Edge add: one transfer per cycle while busy is low, written straight into the adjacency RAMs.
// Finish: a depth-first walk reading one neighbor bit per cycle while scanning, then done
// strobes for one cycle; the receiver cannot stall it.
// After each result and after reset a clearing pass over every adjacency RAM address
// sweeps the adjacency RAMs with busy high; config writes are taken anytime.
module bipartite_min_side_cover
    import bmsc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [VERT_IN_W-1:0] end_a,
    input  logic [VERT_IN_W-1:0] end_b,
    input  logic                 cfg_wr_en,
    input  logic [VERT_IN_W-1:0] cfg_wr_data,
    output logic                 done,
    output logic [TOTAL_W-1:0]   min_guards,
    output logic                 impossible
);

    bmsc_cmd_t    dp_cmd;
    bmsc_status_t status;

    bmsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    bmsc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .status      (status),
        .end_a       (end_a),
        .end_b       (end_b),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .min_guards  (min_guards),
        .impossible  (impossible)
    );

endmodule

// ===== tb/bipartite_min_side_cover_tb.sv =====
// Testbench for bipartite_min_side_cover: queued edge/finish traffic against a predictor.
`timescale 1ns / 1ps

module bipartite_min_side_cover_tb;
    import bmsc_pkg::*;

    localparam int MAX_V         = 64;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 5000;
    localparam int CYCLE_LIMIT   = 60_000_000;

    typedef enum logic [1:0] {
        STEP_XFER,
        STEP_VCOUNT,
        STEP_PAUSE
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic                 op;
        logic [VERT_IN_W-1:0] a;
        logic [VERT_IN_W-1:0] b;
        logic [VERT_IN_W-1:0] vcount;
    } graph_step_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] guards;
        logic               impossible;
    } cover_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 cmd = CMD_ADD_EDGE;
    logic [VERT_IN_W-1:0] end_a = '0;
    logic [VERT_IN_W-1:0] end_b = '0;
    logic                 cfg_wr_en = 1'b0;
    logic [VERT_IN_W-1:0] cfg_wr_data = '0;
    logic                 done;
    logic [TOTAL_W-1:0]   min_guards;
    logic                 impossible;

    graph_step_t          graph_steps[$];
    cover_t               pending_covers[$];
    int unsigned          planned_items = 0;
    logic [VERT_IN_W-1:0] plan_vcount = NUM_VERTICES_RESET;
    int unsigned          mismatch_count = 0;

    // predictor state
    logic [MAX_V-1:0]     graph_adj [MAX_V];
    logic [VERT_IN_W-1:0] model_vcount = NUM_VERTICES_RESET;

    logic                 taken = 1'b0;
    logic                 busy_q = 1'b1;
    int                   idle_left = 0;
    int                   burst_left = 1;
    int                   settle_left = SETTLE_CYCLES;

    bipartite_min_side_cover #(
        .MAX_VERTICES(MAX_V)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .end_a      (end_a),
        .end_b      (end_b),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .min_guards (min_guards),
        .impossible (impossible)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned effective_count(logic [VERT_IN_W-1:0] v);
        return (v > MAX_V) ? MAX_V : int'(v);
    endfunction

    function automatic cover_t solve_cover(int unsigned nv);
        logic [MAX_V-1:0] seen;
        logic [MAX_V-1:0] side;
        int unsigned      walk [MAX_V];
        int unsigned      depth, u, ones, zeros, least, total;
        logic             cu, clash;
        cover_t           res;
        seen  = '0;
        side  = '0;
        total = 0;
        clash = 1'b0;
        for (int unsigned s = 0; s < nv; s++)
        begin
            if (!seen[s])
            begin
                seen[s] = 1'b1;
                side[s] = 1'b1;
                ones    = 1;
                zeros   = 0;
                walk[0] = s;
                depth   = 1;
                while (depth > 0)
                begin
                    depth--;
                    u  = walk[depth];
                    cu = side[u];
                    for (int unsigned w = 0; w < nv; w++)
                    begin
                        if (graph_adj[u][w])
                        begin
                            if (!seen[w])
                            begin
                                seen[w] = 1'b1;
                                if (!cu)
                                begin
                                    side[w] = 1'b1;
                                    ones++;
                                end
                                else
                                begin
                                    zeros++;
                                end
                                walk[depth] = w;
                                depth++;
                            end
                            else if (side[w] == cu)
                            begin
                                clash = 1'b1;
                            end
                        end
                    end
                end
                least = (ones < zeros) ? ones : zeros;
                total = total + least;
                if (total > TOTAL_MAX) total = TOTAL_MAX;
            end
        end
        res.impossible = clash;
        res.guards     = clash ? '0 : total[TOTAL_W-1:0];
        return res;
    endfunction

    function automatic void queue_edge(int unsigned a, int unsigned b);
        graph_step_t st;
        st = '{kind: STEP_XFER, op: CMD_ADD_EDGE, a: a[VERT_IN_W-1:0], b: b[VERT_IN_W-1:0],
               vcount: '0};
        graph_steps.push_back(st);
        planned_items++;
    endfunction

    function automatic void queue_finish(int unsigned a, int unsigned b);
        graph_step_t st;
        st = '{kind: STEP_XFER, op: CMD_FINISH, a: a[VERT_IN_W-1:0], b: b[VERT_IN_W-1:0],
               vcount: '0};
        graph_steps.push_back(st);
        planned_items++;
    endfunction

    function automatic void queue_vertex_count(int unsigned v);
        graph_step_t st;
        st = '{kind: STEP_VCOUNT, op: CMD_ADD_EDGE, a: '0, b: '0, vcount: v[VERT_IN_W-1:0]};
        graph_steps.push_back(st);
        plan_vcount = v[VERT_IN_W-1:0];
    endfunction

    function automatic void queue_pause();
        graph_step_t st;
        st = '{kind: STEP_PAUSE, op: CMD_ADD_EDGE, a: '0, b: '0, vcount: '0};
        graph_steps.push_back(st);
    endfunction

    // Mostly bipartite graphs over a random two-sided split, some unconstrained, some noise.
    function automatic void plan_random_graph();
        int unsigned      roll, nv, lim, edges, style, a, b, tries;
        logic [MAX_V-1:0] half;
        roll = $urandom_range(0, 99);
        if (roll < 65) nv = $urandom_range(1, 12);
        else if (roll < 85) nv = $urandom_range(13, 40);
        else nv = $urandom_range(41, 64);
        if ($urandom_range(0, 19) == 0) queue_vertex_count($urandom_range(0, 127));
        else if ($urandom_range(0, 9) != 0) queue_vertex_count(nv);
        nv    = effective_count(plan_vcount);
        lim   = (nv == 0) ? 1 : nv;
        half  = {$urandom, $urandom};
        style = $urandom_range(0, 3);
        edges = $urandom_range(0, (2 * nv < 30) ? 2 * nv : 30);
        for (int unsigned e = 0; e < edges; e++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_edge($urandom_range(0, 127), $urandom_range(0, 127));
            end
            else
            begin
                a = $urandom_range(1, lim);
                b = $urandom_range(1, lim);
                if (style != 2)
                begin
                    for (tries = 0; tries < 8 && half[a-1] == half[b-1]; tries++)
                        b = $urandom_range(1, lim);
                end
                queue_edge(a, b);
            end
        end
        if (style == 3) queue_edge($urandom_range(1, lim), $urandom_range(1, lim));
        if ($urandom_range(0, 11) == 0) queue_vertex_count($urandom_range(0, 64));
        queue_finish($urandom_range(0, 127), $urandom_range(0, 127));
    endfunction

    // driver
    always @(negedge clk)
    begin
        graph_step_t nxt;
        logic        cfg_pulse;
        int          roll;
        cfg_pulse = 1'b0;
        if (rst_n && !(start && !taken))
        begin
            if (idle_left > 0)
            begin
                start <= 1'b0;
                idle_left--;
            end
            else if (graph_steps.size() == 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                nxt = graph_steps[0];
                if (nxt.kind == STEP_XFER)
                begin
                    start <= 1'b1;
                    cmd   <= nxt.op;
                    end_a <= nxt.a;
                    end_b <= nxt.b;
                    void'(graph_steps.pop_front());
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        roll = $urandom_range(0, 9);
                        if (roll == 0) idle_left = $urandom_range(30, 150);
                        else if (roll < 7) idle_left = $urandom_range(1, 6);
                        else idle_left = 0;
                        if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 80);
                        else burst_left = $urandom_range(1, 10);
                    end
                end
                else
                begin
                    // register writes and pauses wait for an idle block
                    start <= 1'b0;
                    if (pending_covers.size() != 0 || busy_q)
                    begin
                        settle_left = SETTLE_CYCLES;
                    end
                    else if (settle_left > 0)
                    begin
                        settle_left--;
                    end
                    else
                    begin
                        if (nxt.kind == STEP_VCOUNT)
                        begin
                            cfg_pulse = 1'b1;
                            cfg_wr_data <= nxt.vcount;
                        end
                        void'(graph_steps.pop_front());
                        settle_left = SETTLE_CYCLES;
                    end
                end
            end
        end
        cfg_wr_en <= cfg_pulse;
    end

    // predictor and monitor
    always @(posedge clk)
    begin
        cover_t      want;
        int unsigned nv, ia, ib;
        if (!rst_n)
        begin
            taken  <= 1'b0;
            busy_q <= 1'b1;
            for (int i = 0; i < MAX_V; i++) graph_adj[i] = '0;
            model_vcount = NUM_VERTICES_RESET;
        end
        else
        begin
            taken  <= start && !busy;
            busy_q <= busy;
            if (done)
            begin
                if (pending_covers.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d %0b",
                             $time, min_guards, impossible);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_covers.pop_front();
                    if (min_guards !== want.guards)
                    begin
                        $display("%0t: min_guards mismatch: expected %0d actual %0d",
                                 $time, want.guards, min_guards);
                        mismatch_count++;
                    end
                    if (impossible !== want.impossible)
                    begin
                        $display("%0t: impossible mismatch: expected %0b actual %0b",
                                 $time, want.impossible, impossible);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) model_vcount = cfg_wr_data;
            if (start && !busy)
            begin
                nv = effective_count(model_vcount);
                if (cmd == CMD_ADD_EDGE)
                begin
                    ia = end_a;
                    ib = end_b;
                    if (ia >= 1 && ia <= nv && ib >= 1 && ib <= nv)
                    begin
                        graph_adj[ia-1][ib-1] = 1'b1;
                        graph_adj[ib-1][ia-1] = 1'b1;
                    end
                end
                else
                begin
                    pending_covers.push_back(solve_cover(nv));
                    for (int i = 0; i < MAX_V; i++) graph_adj[i] = '0;
                end
            end
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        // reset count, duplicate edge, dropped endpoints
        queue_edge(1, 64);
        queue_edge(64, 1);
        queue_edge(0, 5);
        queue_edge(65, 3);
        queue_edge(127, 127);
        queue_finish(127, 0);
        // self loop
        queue_edge(3, 3);
        queue_finish(0, 127);
        queue_pause();
        // empty graph
        queue_vertex_count(0);
        queue_edge(1, 1);
        queue_finish(1, 1);
        // count above the maximum, odd cycle
        queue_vertex_count(127);
        queue_edge(1, 2);
        queue_edge(2, 3);
        queue_edge(3, 1);
        queue_edge(64, 63);
        queue_finish(0, 0);
        queue_vertex_count(1);
        queue_finish(64, 64);
        // count lowered after loading
        queue_vertex_count(10);
        queue_edge(1, 2);
        queue_edge(9, 10);
        queue_edge(10, 11);
        queue_vertex_count(5);
        queue_finish(0, 0);
        queue_vertex_count(64);
        queue_edge(1, 2);
        queue_edge(2, 3);
        queue_edge(3, 4);
        queue_finish(127, 127);

        while (planned_items < 24 + RANDOM_ITEMS)
        begin
            plan_random_graph();
            if ($urandom_range(0, 14) == 0) queue_pause();
        end

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (graph_steps.size() != 0 || start || pending_covers.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_covers.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
